>>> src/fbpc_pkg.sv
// fbpc_pkg: shared types, class codes and signature constants for the
// first-bytes protocol classifier. No dependencies.

package fbpc_pkg;

   // Result class codes
   typedef enum logic [2:0] {
      CLS_NONE    = 3'd0,
      CLS_ADCHUB  = 3'd1,
      CLS_NMDC    = 3'd2,
      CLS_ADC     = 3'd3,
      CLS_HTTP    = 3'd4,
      CLS_TLS     = 3'd5,
      CLS_UNKNOWN = 3'd6
   } class_type;

   // Control register indexes; register i sits at byte address 4*i
   localparam logic [1:0] REG_TLS_ENABLE  = 2'd0;
   localparam logic [1:0] REG_NAT_ENABLE  = 2'd1;
   localparam logic [1:0] REG_HUB_PRESENT = 2'd2;
   localparam logic [1:0] REG_HTTP_ENABLE = 2'd3;

   localparam int unsigned HEAD_BYTES = 16;

   // Stream signatures
   localparam logic [31:0] SIG_HSUP = 32'h4853_5550;
   localparam logic [31:0] SIG_CSUP = 32'h4353_5550;
   localparam logic [63:0] SIG_NICK = 64'h244D_794E_6963_6B20; // "$MyNick "

   localparam int unsigned HTTP_CODES = 7;
   localparam logic [31:0] SIG_HTTP [HTTP_CODES] = '{
      32'h4745_5420,  // "GET "
      32'h4845_4144,  // "HEAD"
      32'h504F_5354,  // "POST"
      32'h5055_5420,  // "PUT "
      32'h5452_4143,  // "TRAC"
      32'h4445_4C45,  // "DELE"
      32'h4F50_5449   // "OPTI"
   };

   // Datagram codes
   localparam logic [31:0] SIG_USCH = 32'h5553_4348;
   localparam logic [31:0] SIG_URES = 32'h5552_4553;
   localparam logic [31:0] SIG_USTA = 32'h5553_5441;
   localparam logic [31:0] SIG_UTUN = 32'h5554_554E;
   localparam logic [31:0] SIG_UECO = 32'h5545_434F;
   localparam logic [31:0] SIG_HTUN = 32'h4854_554E;
   localparam logic [31:0] SIG_HECO = 32'h4845_434F;
   localparam logic [31:0] SIG_SR   = 32'h2453_5220;  // "$SR "
   localparam logic [31:0] SIG_PIN  = 32'h2450_696E;  // "$Pin"

   // TLS / SSL handshake bytes
   localparam logic [7:0] TLS_HANDSHAKE = 8'd22;
   localparam logic [7:0] TLS_HELLO     = 8'd1;
   localparam logic [7:0] TLS_MAJOR3    = 8'd3;

   typedef struct packed {
      logic tls_enable;
      logic nat_traversal_enable;
      logic hub_present;
      logic http_enable;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [63:0] head_bytes_hi;
      logic [63:0] head_bytes_lo;
      logic [4:0]  byte_count;
   } req_type;

   typedef struct packed {
      class_type   protocol_class;
      logic        accepted;
      logic [7:0]  tls_major;
      logic [7:0]  tls_minor;
   } rsp_type;

   function automatic logic is_http(input logic [31:0] code);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < HTTP_CODES; k++) begin
         if (SIG_HTTP[k] == code) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

>>> src/first_bytes_protocol_classifier.sv
// first_bytes_protocol_classifier: top level, request/result pipeline and
// control registers. Depends on fbpc_pkg and fbpc_match.

// Classifies the first sixteen bytes of a new stream connection or of a
// datagram by fixed signatures. Each request is captured in an input
// register, compared against all signatures in combinational logic
// (fbpc_match), and the result lands in an output register. One request is
// taken every cycle while rsp_tready does not hold the output register back;
// even then a new request can still be taken into an empty input register
// while a finished result waits for rsp_tready.
// Streams are tried in priority order ADC hub, NMDC, ADC client, HTTP, then
// SSLv3/TLS or SSLv2 (16 bytes needed); datagrams by their four-character
// code. Control registers at byte addresses 0x0 tls_enable (reset 1),
// 0x4 nat_traversal_enable, 0x8 hub_present, 0xC http_enable (bit 0 each);
// write them only while no request is in flight.

module first_bytes_protocol_classifier import fbpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [63:0] head_bytes_hi, [127:64] head_bytes_lo, [132:128] byte_count,
   // [135:133] zero
   input  logic [135:0] req_tdata,
   // [0] opcode
   input  logic         req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] protocol_class, [3] accepted, [11:4] tls_major, [19:12] tls_minor,
   // [23:20] zero
   output logic [23:0]  rsp_tdata,

   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   cfg_type    cfg_ff;
   logic       csr_write;
   logic [1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tls_enable           <= 1'b1;
         cfg_ff.nat_traversal_enable <= 1'b0;
         cfg_ff.hub_present          <= 1'b0;
         cfg_ff.http_enable          <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TLS_ENABLE:  cfg_ff.tls_enable           <= csr_pwdata[0];
            REG_NAT_ENABLE:  cfg_ff.nat_traversal_enable <= csr_pwdata[0];
            REG_HUB_PRESENT: cfg_ff.hub_present          <= csr_pwdata[0];
            REG_HTTP_ENABLE: cfg_ff.http_enable          <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TLS_ENABLE:  csr_prdata = {31'd0, cfg_ff.tls_enable};
         REG_NAT_ENABLE:  csr_prdata = {31'd0, cfg_ff.nat_traversal_enable};
         REG_HUB_PRESENT: csr_prdata = {31'd0, cfg_ff.hub_present};
         REG_HTTP_ENABLE: csr_prdata = {31'd0, cfg_ff.http_enable};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline: input register -> compare logic -> output register
   // ---------------------------------------------------------------
   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type match_rsp;
   logic    out_load;     // output register takes the input stage
   logic    req_take;

   // output register free when empty or being drained this cycle
   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.opcode        <= req_tuser;
         in_req_ff.head_bytes_hi <= req_tdata[63:0];
         in_req_ff.head_bytes_lo <= req_tdata[127:64];
         in_req_ff.byte_count    <= req_tdata[132:128];
      end
      if (out_load) begin
         out_rsp_ff <= match_rsp;
      end
   end

   fbpc_match u_match (
      .req (in_req_ff),
      .cfg (cfg_ff),
      .rsp (match_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_rsp_ff.tls_minor, out_rsp_ff.tls_major,
                        out_rsp_ff.accepted, out_rsp_ff.protocol_class};

endmodule

>>> src/fbpc_match.sv
// fbpc_match: signature compare logic for one probe, stream or datagram.
// Depends on fbpc_pkg.

module fbpc_match import fbpc_pkg::*; (
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic [4:0]  len;
   logic [31:0] code;
   logic [7:0]  b0, b1, b2, b3, b4, b5, b9, b10;
   logic        ge4, ge8, ge16;
   logic        nick;

   always_comb begin
      len  = (req.byte_count > 5'(HEAD_BYTES)) ? 5'(HEAD_BYTES) : req.byte_count;
      code = req.head_bytes_hi[63:32];
      b0   = req.head_bytes_hi[63:56];
      b1   = req.head_bytes_hi[55:48];
      b2   = req.head_bytes_hi[47:40];
      b3   = req.head_bytes_hi[39:32];
      b4   = req.head_bytes_hi[31:24];
      b5   = req.head_bytes_hi[23:16];
      b9   = req.head_bytes_lo[55:48];
      b10  = req.head_bytes_lo[47:40];
      ge4  = len >= 5'd4;
      ge8  = len >= 5'd8;
      ge16 = len >= 5'(HEAD_BYTES);
      nick = ge8 && (req.head_bytes_hi == SIG_NICK);
   end

   always_comb begin
      rsp.protocol_class = CLS_UNKNOWN;
      rsp.accepted       = 1'b0;
      rsp.tls_major      = '0;
      rsp.tls_minor      = '0;
      if (!req.opcode) begin
         if (len == '0) begin
            rsp.protocol_class = CLS_NONE;
         end else if (ge4 && code == SIG_HSUP) begin
            rsp.protocol_class = CLS_ADCHUB;
            rsp.accepted       = cfg.hub_present;
         end else if (nick) begin
            rsp.protocol_class = CLS_NMDC;
            rsp.accepted       = 1'b1;
         end else if (ge4 && code == SIG_CSUP) begin
            rsp.protocol_class = CLS_ADC;
            rsp.accepted       = 1'b1;
         end else if (ge4 && is_http(code)) begin
            rsp.protocol_class = CLS_HTTP;
            rsp.accepted       = cfg.http_enable;
         end else if (cfg.tls_enable && ge16) begin
            if (b0 == TLS_HANDSHAKE) begin
               // SSLv3/TLS record: version repeated in the client hello
               if (b5 == TLS_HELLO && b1 == TLS_MAJOR3 && b9 == b1 && b10 == b2) begin
                  rsp.protocol_class = CLS_TLS;
                  rsp.tls_major      = b1;
                  rsp.tls_minor      = b2;
               end
            end else if (b0[7]) begin
               // SSLv2 two-byte header
               if (b2 == TLS_HELLO && b3 == TLS_MAJOR3) begin
                  rsp.protocol_class = CLS_TLS;
                  rsp.tls_major      = b3;
                  rsp.tls_minor      = b4;
               end
            end
         end
      end else begin
         if (!ge4) begin
            rsp.protocol_class = CLS_NONE;
         end else if (code == SIG_USCH || code == SIG_URES || code == SIG_USTA ||
                      (cfg.nat_traversal_enable &&
                       (code == SIG_UTUN || code == SIG_UECO))) begin
            rsp.protocol_class = CLS_ADC;
         end else if (cfg.nat_traversal_enable &&
                      (code == SIG_HTUN || code == SIG_HECO)) begin
            rsp.protocol_class = CLS_ADCHUB;
         end else if (code == SIG_SR || code == SIG_PIN) begin
            rsp.protocol_class = CLS_NMDC;
         end
      end
   end

endmodule

>>> src/fbpc_checker.sv
// fbpc_checker: port-level assertions for the classifier, bound to the
// top level. Depends on fbpc_pkg.

module fbpc_checker import fbpc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic [2:0] cls;
   assign cls = rsp_tdata[2:0];

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a taken request is followed by a valid result on rsp_tvalid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> ##2 rsp_tvalid)
      else $error("request result missing");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // only handled stream classes may be accepted
   a_accept_class: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |->
      (cls == CLS_ADCHUB || cls == CLS_NMDC || cls == CLS_ADC || cls == CLS_HTTP))
      else $error("accepted on non-handled class");

   a_version_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && cls != CLS_TLS) |-> (rsp_tdata[19:4] == 16'd0))
      else $error("version set on non-tls result");

endmodule

bind first_bytes_protocol_classifier fbpc_checker u_fbpc_checker (.*);

>>> bench/first_bytes_protocol_classifier_tb.sv
// first_bytes_protocol_classifier_tb: self-checking bench for the first-bytes
// protocol classifier. It drives stream and datagram probes, predicts each
// verdict in place and checks it. Depends on fbpc_pkg and the classifier RTL.

module first_bytes_protocol_classifier_tb;
   import fbpc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned PHASE_REQUESTS = 145;

   // Opcode values of a probe
   localparam logic OP_STREAM   = 1'b0;
   localparam logic OP_DATAGRAM = 1'b1;

   // Every datagram code the block knows, NAT-traversal ones included
   localparam logic [31:0] DGRAM_CODES [9] = '{
      SIG_USCH, SIG_URES, SIG_USTA, SIG_UTUN, SIG_UECO,
      SIG_HTUN, SIG_HECO, SIG_SR, SIG_PIN
   };

   logic         clock;
   logic         reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // [63:0] head_bytes_hi, [127:64] head_bytes_lo, [132:128] byte_count,
   // [135:133] zero
   logic [135:0] req_tdata = '0;
   // [0] opcode
   logic         req_tuser = 1'b0;

   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // [2:0] protocol_class, [3] accepted, [11:4] tls_major, [19:12] tls_minor,
   // [23:20] zero
   logic [23:0]  rsp_tdata;

   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   first_bytes_protocol_classifier DUT (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // Shadow of the control registers, reset values
   cfg_type     cfg_shadow = '{tls_enable: 1'b1, nat_traversal_enable: 1'b0,
                               hub_present: 1'b0, http_enable: 1'b0};

   req_type     pending_probes [$];     // waiting for the driver
   rsp_type     expected_verdicts [$];  // predicted, waiting for the block
   int unsigned probes_queued = 0;
   int unsigned probes_taken  = 0;
   int unsigned fail_count    = 0;
   int unsigned cycle_count   = 0;

   logic        req_hs = 1'b0;          // request accepted at last rising edge
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Verdict predictor. Stream priority: hub, nick, client, http, tls.
   // Byte count above sixteen saturates; bytes are unsigned.
   // ---------------------------------------------------------------------
   function automatic rsp_type classify_head(input cfg_type cfg, input req_type p);
      logic [127:0] head;
      logic [7:0]   hb [16];
      logic [31:0]  code;
      logic [4:0]   len;
      logic         http_hit;
      rsp_type      r;
      head = {p.head_bytes_hi, p.head_bytes_lo};
      for (int i = 0; i < 16; i++) hb[i] = head[127 - 8 * i -: 8];
      len  = (p.byte_count > 5'd16) ? 5'd16 : p.byte_count;
      code = head[127:96];
      http_hit = 1'b0;
      for (int k = 0; k < HTTP_CODES; k++) begin
         if (SIG_HTTP[k] == code) http_hit = 1'b1;
      end
      r = '{protocol_class: CLS_UNKNOWN, accepted: 1'b0, tls_major: 8'd0, tls_minor: 8'd0};

      if (p.opcode == OP_STREAM) begin
         if (len == 5'd0) begin
            r.protocol_class = CLS_NONE;
         end else if (len >= 5'd4 && code == SIG_HSUP) begin
            r.protocol_class = CLS_ADCHUB;
            r.accepted = cfg.hub_present;
         end else if (len >= 5'd8 && head[127:64] == SIG_NICK) begin
            r.protocol_class = CLS_NMDC;
            r.accepted = 1'b1;
         end else if (len >= 5'd4 && code == SIG_CSUP) begin
            r.protocol_class = CLS_ADC;
            r.accepted = 1'b1;
         end else if (len >= 5'd4 && http_hit) begin
            r.protocol_class = CLS_HTTP;
            r.accepted = cfg.http_enable;
         end else if (cfg.tls_enable && len >= 5'd16) begin
            if (hb[0] == TLS_HANDSHAKE) begin
               // SSLv3/TLS record: hello, major 3, version repeated in body
               if (hb[5] == TLS_HELLO && hb[1] == TLS_MAJOR3 &&
                   hb[9] == hb[1] && hb[10] == hb[2]) begin
                  r.protocol_class = CLS_TLS;
                  r.tls_major = hb[1];
                  r.tls_minor = hb[2];
               end
            end else if (hb[0][7]) begin
               // SSLv2 header: two-byte length with top bit set
               if (hb[2] == TLS_HELLO && hb[3] == TLS_MAJOR3) begin
                  r.protocol_class = CLS_TLS;
                  r.tls_major = hb[3];
                  r.tls_minor = hb[4];
               end
            end
         end
      end else begin
         if (len < 5'd4) begin
            r.protocol_class = CLS_NONE;
         end else if (code == SIG_USCH || code == SIG_URES || code == SIG_USTA ||
                      (cfg.nat_traversal_enable &&
                       (code == SIG_UTUN || code == SIG_UECO))) begin
            r.protocol_class = CLS_ADC;
         end else if (cfg.nat_traversal_enable &&
                      (code == SIG_HTUN || code == SIG_HECO)) begin
            r.protocol_class = CLS_ADCHUB;
         end else if (code == SIG_SR || code == SIG_PIN) begin
            r.protocol_class = CLS_NMDC;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Byte counts cluster on the thresholds 4, 8 and 16; bit 4 also sees
   // the saturating values above sixteen.
   function automatic logic [4:0] pick_count();
      logic [4:0] c;
      case ($urandom_range(0, 7))
         0, 1, 2: c = 5'd16;
         3:       c = 5'($urandom_range(17, 31));
         4:       c = 5'($urandom_range(0, 31));
         5: begin
            case ($urandom_range(0, 4))
               0: c = 5'd3;
               1: c = 5'd4;
               2: c = 5'd7;
               3: c = 5'd8;
               default: c = 5'd15;
            endcase
         end
         default: c = 5'($urandom_range(8, 16));
      endcase
      return c;
   endfunction

   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
   endfunction

   function automatic req_type random_probe();
      logic [127:0] head;
      logic [4:0]   count;
      logic         op;
      head  = {$urandom, $urandom, $urandom, $urandom};
      count = pick_count();
      op    = OP_STREAM;
      case ($urandom_range(0, 15))
         0: head[127:96] = SIG_HSUP;
         1: head[127:64] = SIG_NICK;
         2: head[127:96] = SIG_CSUP;
         3: head[127:96] = SIG_HTTP[$urandom_range(0, HTTP_CODES - 1)];
         4, 5: begin
            // well-formed SSLv3/TLS hello, sometimes with one byte off
            head[127:120] = TLS_HANDSHAKE;
            head[119:112] = TLS_MAJOR3;
            head[87:80]   = TLS_HELLO;
            head[55:48]   = TLS_MAJOR3;
            head[47:40]   = head[111:104];
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 3))
                  0: head[119:112] ^= 8'($urandom_range(1, 255));
                  1: head[87:80]   ^= 8'($urandom_range(1, 255));
                  2: head[55:48]   ^= 8'($urandom_range(1, 255));
                  default: head[47:40] ^= 8'($urandom_range(1, 255));
               endcase
            end
            if ($urandom_range(0, 3) != 0)
               count = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) : 5'd16;
         end
         6: begin
            // SSLv2 hello, sometimes broken
            head[127]     = 1'b1;
            head[111:104] = TLS_HELLO;
            head[103:96]  = TLS_MAJOR3;
            if ($urandom_range(0, 3) == 0) begin
               case ($urandom_range(0, 2))
                  0: head[111:104] ^= 8'($urandom_range(1, 255));
                  1: head[103:96]  ^= 8'($urandom_range(1, 255));
                  default: head[127] = 1'b0;
               endcase
            end
            if ($urandom_range(0, 3) != 0) count = 5'd16;
         end
         7: head[127:120] = TLS_HANDSHAKE;
         8, 9, 10, 11: begin
            op = OP_DATAGRAM;
            head[127:96] = DGRAM_CODES[$urandom_range(0, 8)];
         end
         12: op = OP_DATAGRAM;
         13: begin
            // near miss: a stream signature with one bit flipped
            case ($urandom_range(0, 3))
               0: head[127:96] = SIG_HSUP;
               1: head[127:64] = SIG_NICK;
               2: head[127:96] = SIG_CSUP;
               default: head[127:96] = SIG_HTTP[$urandom_range(0, HTTP_CODES - 1)];
            endcase
            head[127 - $urandom_range(0, 63)] ^= 1'b1;
         end
         default: ;  // plain noise stream
      endcase
      return '{opcode: op, head_bytes_hi: head[127:64], head_bytes_lo: head[63:0],
               byte_count: count};
   endfunction

   task automatic queue_probe(input logic op, input logic [127:0] head,
                              input logic [4:0] count);
      pending_probes.push_back('{opcode: op, head_bytes_hi: head[127:64],
                                 head_bytes_lo: head[63:0], byte_count: count});
      probes_queued++;
   endtask

   task automatic queue_random(input int unsigned n);
      repeat (n) begin
         pending_probes.push_back(random_probe());
         probes_queued++;
      end
   endtask

   // APB write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [1:0] idx, input logic bitval);
      logic [31:0] word;
      word = $urandom;
      word[0] = bitval;   // only bit 0 is meaningful
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_TLS_ENABLE:  cfg_shadow.tls_enable = bitval;
         REG_NAT_ENABLE:  cfg_shadow.nat_traversal_enable = bitval;
         REG_HUB_PRESENT: cfg_shadow.hub_present = bitval;
         REG_HTTP_ENABLE: cfg_shadow.http_enable = bitval;
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_config(input cfg_type c);
      csr_write(REG_TLS_ENABLE,  c.tls_enable);
      csr_write(REG_NAT_ENABLE,  c.nat_traversal_enable);
      csr_write(REG_HUB_PRESENT, c.hub_present);
      csr_write(REG_HTTP_ENABLE, c.http_enable);
   endtask

   // Idle: every queued request taken and every verdict back, then
   // DRAIN_CYCLES more so the two-stage pipe is empty. Counters settle at rising edges.
   task automatic wait_idle();
      do @(negedge clock);
      while (probes_taken != probes_queued || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps in between.
   // A new request goes out only once the last one was taken.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      req_type probe;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_probes.size() != 0) begin
            probe = pending_probes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {3'b000, probe.byte_count, probe.head_bytes_lo,
                           probe.head_bytes_hi};
            req_tuser  <= probe.opcode;
            if (burst_left <= 1) begin
               // now and then a long burst with no gap at all
               burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 16);
               gap_left   <= pick_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side back-pressure: modes of always ready, random, mostly
   // ready, and long stalls, each held for a random stretch.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: begin
               if (stall_left != 0) begin
                  stall_left <= stall_left - 1;
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 20);
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted result
   // against the oldest prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      req_type seen;
      rsp_type want;
      req_hs <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen = '{opcode: req_tuser, head_bytes_hi: req_tdata[63:0],
                     head_bytes_lo: req_tdata[127:64], byte_count: req_tdata[132:128]};
            expected_verdicts.push_back(classify_head(cfg_shadow, seen));
            probes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result: rsp_tdata %h with no request pending", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[2:0] !== want.protocol_class) begin
                  $error("protocol_class: expected %0d, actual %0d",
                         want.protocol_class, rsp_tdata[2:0]);
                  fail_count++;
               end
               if (rsp_tdata[3] !== want.accepted) begin
                  $error("accepted: expected %0d, actual %0d", want.accepted, rsp_tdata[3]);
                  fail_count++;
               end
               if (rsp_tdata[11:4] !== want.tls_major) begin
                  $error("tls_major: expected %0d, actual %0d", want.tls_major,
                         rsp_tdata[11:4]);
                  fail_count++;
               end
               if (rsp_tdata[19:12] !== want.tls_minor) begin
                  $error("tls_minor: expected %0d, actual %0d", want.tls_minor,
                         rsp_tdata[19:12]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : run_test
      cfg_type phase_cfg;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests at reset settings (tls on, the rest off)
      queue_probe(OP_STREAM, 128'h0, 5'd0);                       // empty stream
      queue_probe(OP_STREAM, {SIG_HSUP, 96'h0}, 5'd4);            // hub, no hub
      queue_probe(OP_STREAM, {SIG_HSUP, 96'h0}, 5'd3);            // too short
      queue_probe(OP_STREAM, {SIG_NICK, 64'h0}, 5'd8);
      queue_probe(OP_STREAM, {SIG_NICK, 64'h0}, 5'd7);            // nick cut short
      queue_probe(OP_STREAM, {SIG_CSUP, 96'h0}, 5'd4);
      for (int k = 0; k < HTTP_CODES; k++)
         queue_probe(OP_STREAM, {SIG_HTTP[k], 96'h0}, 5'd4);
      // SSLv3/TLS 3.1 hello, full and one byte short
      queue_probe(OP_STREAM, 128'h1603_0100_4001_0000_3C03_0100_0000_0000, 5'd16);
      queue_probe(OP_STREAM, 128'h1603_0100_4001_0000_3C03_0100_0000_0000, 5'd15);
      // SSLv2 hellos, top bit set in the length byte
      queue_probe(OP_STREAM, 128'h8046_0103_0100_2D00_0000_1000_0000_0000, 5'd16);
      queue_probe(OP_STREAM, 128'hFF00_0103_02FF_FFFF_FFFF_FFFF_FFFF_FFFF, 5'd16);
      // all ones, count saturates
      queue_probe(OP_STREAM, {128{1'b1}}, 5'd31);
      // datagrams: short ones, each code, and a miss
      queue_probe(OP_DATAGRAM, {SIG_USCH, 96'h0}, 5'd3);
      queue_probe(OP_DATAGRAM, 128'h0, 5'd0);
      for (int k = 0; k < 9; k++)
         queue_probe(OP_DATAGRAM, {DGRAM_CODES[k], 96'h0}, 5'd4);
      queue_probe(OP_DATAGRAM, {128{1'b1}}, 5'd31);
      queue_random(PHASE_REQUESTS);
      wait_idle();

      // Phases under different settings: all off, all on, random, reset-like
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       phase_cfg = 4'b0000;
            1:       phase_cfg = 4'b1111;
            7:       phase_cfg = 4'b1000;
            default: phase_cfg = cfg_type'(4'($urandom_range(0, 15)));
         endcase
         write_config(phase_cfg);
         queue_random(PHASE_REQUESTS);
         wait_idle();
      end

      if (expected_verdicts.size() != 0) begin
         $error("%0d predicted results never arrived", expected_verdicts.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
